[src/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared types, constants and helper functions of the complex ALU pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DW           = 32;
    localparam int FB           = 16;
    localparam int DIV_STEPS    = 33;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 24;
    localparam int NUM_CELLS    = 33;
    localparam int ANG_FRAC     = 60;
    localparam int CORDIC_GUARD = 24;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // operation kinds
    typedef enum logic [3:0] {
        K_ADD   = 4'd0,
        K_SUB   = 4'd1,
        K_MUL   = 4'd2,
        K_DIV   = 4'd3,
        K_NEG   = 4'd4,
        K_CONJ  = 4'd5,
        K_SCALE = 4'd6,
        K_POLAR = 4'd7,
        K_CMP   = 4'd8
    } kind_t;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_ARG  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    // payload handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [3:0]         kind;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               eq;
        logic               clip;
        logic               dzero;
        logic [79:0]        rre;
        logic [79:0]        rim;
        logic [32:0]        qre;
        logic [32:0]        qim;
        logic               nre;
        logic               nim;
        logic               ore;
        logic               oim;
        logic [63:0]        dv;
        logic [63:0]        srem;
        logic [31:0]        root;
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] cz;
        logic               origin;
        logic               ar_zero;
        logic               ar_neg;
        logic               ai_zero;
        logic               ai_neg;
    } cell_t;

    // saturate to 32 bits; bit 32 of the result is the clip flag
    function automatic logic [32:0] sat32(input logic signed [64:0] v);
        logic [32:0] r;
        if (v > 65'sd2147483647)
            r = {1'b1, 32'h7FFFFFFF};
        else if (v < -65'sd2147483648)
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    // 2^(60-k*i) or zero when the exponent goes negative
    function automatic logic [63:0] sh(input int i, input int k);
        logic [63:0] r;
        r = 64'd0;
        if (k * i <= ANG_FRAC)
            r = 64'd1 << (ANG_FRAC - k * i);
        return r;
    endfunction

    // atan(2^-i) with 60 fraction bits, arctangent series
    function automatic logic signed [63:0] atan_step(input int i);
        logic [63:0] acc;
        acc = 64'd0;
        if (i == 0)
            return signed'(PI_Q60 >> 2);
        acc = acc + sh(i, 1);       acc = acc - sh(i, 3) / 3;
        acc = acc + sh(i, 5) / 5;   acc = acc - sh(i, 7) / 7;
        acc = acc + sh(i, 9) / 9;   acc = acc - sh(i, 11) / 11;
        acc = acc + sh(i, 13) / 13; acc = acc - sh(i, 15) / 15;
        acc = acc + sh(i, 17) / 17; acc = acc - sh(i, 19) / 19;
        acc = acc + sh(i, 21) / 21; acc = acc - sh(i, 23) / 23;
        acc = acc + sh(i, 25) / 25; acc = acc - sh(i, 27) / 27;
        acc = acc + sh(i, 29) / 29; acc = acc - sh(i, 31) / 31;
        acc = acc + sh(i, 33) / 33; acc = acc - sh(i, 35) / 35;
        acc = acc + sh(i, 37) / 37; acc = acc - sh(i, 39) / 39;
        acc = acc + sh(i, 41) / 41; acc = acc - sh(i, 43) / 43;
        acc = acc + sh(i, 45) / 45; acc = acc - sh(i, 47) / 47;
        acc = acc + sh(i, 49) / 49; acc = acc - sh(i, 51) / 51;
        acc = acc + sh(i, 53) / 53; acc = acc - sh(i, 55) / 55;
        acc = acc + sh(i, 57) / 57; acc = acc - sh(i, 59) / 59;
        return signed'(acc);
    endfunction

endpackage

[src/cau_front.sv]
// ----------------------------------------------------------------------------
// Complex ALU front end
// Products, sums and setup of the divide, square root and CORDIC chains.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [3:0]          kind,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    input  logic [15:0]         tol,
    output cau_pkg::cell_t      cell_out
);
    import cau_pkg::*;

    typedef struct packed {
        logic               valid;
        logic [3:0]         kind;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               eq;
        logic               clip;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_ii;
        logic signed [63:0] p_ri;
        logic signed [63:0] p_ir;
        logic signed [63:0] p_aa;
        logic signed [63:0] p_bb;
        logic signed [63:0] p_dr;
        logic signed [63:0] p_di;
        logic [32:0]        ax;
        logic [32:0]        ay;
        logic               ar_zero;
        logic               ar_neg;
        logic               ai_zero;
        logic               ai_neg;
    } s1_t;

    typedef struct packed {
        logic               valid;
        logic [3:0]         kind;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               eq;
        logic               clip;
        logic signed [64:0] num_re;
        logic signed [64:0] num_im;
        logic [63:0]        dv;
        logic [63:0]        sv;
        logic [32:0]        ax;
        logic [32:0]        ay;
        logic               ar_zero;
        logic               ar_neg;
        logic               ai_zero;
        logic               ai_neg;
    } s2_t;

    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    cell_t c_reg, c_next;

    // stage 1: multipliers and the simple operations
    always_comb
    begin
        logic [32:0] sr;
        logic [32:0] si;
        logic [32:0] dr;
        logic [32:0] di;
        logic signed [32:0] dre;
        logic signed [32:0] dim;
        sr = '0;
        si = '0;
        dre = 33'(a_re) - 33'(b_re);
        dim = 33'(a_im) - 33'(b_im);
        dr = dre[32] ? 33'(-dre) : dre;
        di = dim[32] ? 33'(-dim) : dim;
        s1_next = '0;
        s1_next.valid = in_valid;
        s1_next.kind  = kind;
        unique case (kind)
            K_ADD:
            begin
                sr = sat32(65'(a_re) + 65'(b_re));
                si = sat32(65'(a_im) + 65'(b_im));
            end
            K_SUB:
            begin
                sr = sat32(65'(a_re) - 65'(b_re));
                si = sat32(65'(a_im) - 65'(b_im));
            end
            K_NEG:
            begin
                sr = sat32(-65'(a_re));
                si = sat32(-65'(a_im));
            end
            K_CONJ:
            begin
                sr = {1'b0, a_re};
                si = sat32(-65'(a_im));
            end
            K_CMP:   s1_next.eq = (dr <= 33'(tol)) && (di <= 33'(tol));
            default: ;
        endcase
        s1_next.re      = sr[31:0];
        s1_next.im      = si[31:0];
        s1_next.clip    = sr[32] | si[32];
        s1_next.p_rr    = 64'(a_re) * 64'(b_re);
        s1_next.p_ii    = 64'(a_im) * 64'(b_im);
        s1_next.p_ri    = 64'(a_re) * 64'(b_im);
        s1_next.p_ir    = 64'(a_im) * 64'(b_re);
        s1_next.p_aa    = 64'(a_re) * 64'(a_re);
        s1_next.p_bb    = 64'(a_im) * 64'(a_im);
        s1_next.p_dr    = 64'(b_re) * 64'(b_re);
        s1_next.p_di    = 64'(b_im) * 64'(b_im);
        s1_next.ax      = a_re[31] ? 33'(-33'(a_re)) : 33'(a_re);
        s1_next.ay      = a_im[31] ? 33'(-33'(a_im)) : 33'(a_im);
        s1_next.ar_zero = (a_re == 32'sd0);
        s1_next.ar_neg  = a_re[31];
        s1_next.ai_zero = (a_im == 32'sd0);
        s1_next.ai_neg  = a_im[31];
    end

    // stage 2: sums of products, product scaling (arithmetic right shift) for mul and scale
    always_comb
    begin
        logic signed [64:0] mre;
        logic signed [64:0] mim;
        logic [32:0] sr;
        logic [32:0] si;
        mre = 65'(s1_reg.p_rr) - 65'(s1_reg.p_ii);
        mim = 65'(s1_reg.p_ri) + 65'(s1_reg.p_ir);
        sr = {s1_reg.clip, s1_reg.re};
        si = {1'b0, s1_reg.im};
        if (s1_reg.kind == K_MUL)
        begin
            sr = sat32(mre >>> FB);
            si = sat32(mim >>> FB);
        end
        else if (s1_reg.kind == K_SCALE)
        begin
            sr = sat32(65'(s1_reg.p_rr) >>> FB);
            si = sat32(65'(s1_reg.p_ir) >>> FB);
        end
        s2_next.valid   = s1_reg.valid;
        s2_next.kind    = s1_reg.kind;
        s2_next.re      = sr[31:0];
        s2_next.im      = si[31:0];
        s2_next.eq      = s1_reg.eq;
        s2_next.clip    = sr[32] | si[32];
        s2_next.num_re  = 65'(s1_reg.p_rr) + 65'(s1_reg.p_ii);
        s2_next.num_im  = 65'(s1_reg.p_ir) - 65'(s1_reg.p_ri);
        s2_next.dv      = $unsigned(s1_reg.p_dr) + $unsigned(s1_reg.p_di);
        s2_next.sv      = $unsigned(s1_reg.p_aa) + $unsigned(s1_reg.p_bb);
        s2_next.ax      = s1_reg.ax;
        s2_next.ay      = s1_reg.ay;
        s2_next.ar_zero = s1_reg.ar_zero;
        s2_next.ar_neg  = s1_reg.ar_neg;
        s2_next.ai_zero = s1_reg.ai_zero;
        s2_next.ai_neg  = s1_reg.ai_neg;
    end

    // stage 3: sign/magnitude split, quotient overflow check, chain setup
    always_comb
    begin
        logic [63:0] mre;
        logic [63:0] mim;
        logic [64:0] tre;
        logic [64:0] tim;
        tre = 65'(-s2_reg.num_re);
        tim = 65'(-s2_reg.num_im);
        mre = s2_reg.num_re[64] ? tre[63:0] : s2_reg.num_re[63:0];
        mim = s2_reg.num_im[64] ? tim[63:0] : s2_reg.num_im[63:0];
        c_next = '0;
        c_next.valid   = s2_reg.valid;
        c_next.kind    = s2_reg.kind;
        c_next.re      = s2_reg.re;
        c_next.im      = s2_reg.im;
        c_next.eq      = s2_reg.eq;
        c_next.clip    = s2_reg.clip;
        c_next.dzero   = (s2_reg.dv == 64'd0);
        c_next.rre     = {mre, 16'd0};
        c_next.rim     = {mim, 16'd0};
        c_next.nre     = s2_reg.num_re[64];
        c_next.nim     = s2_reg.num_im[64];
        c_next.ore     = {17'd0, mre} >= {s2_reg.dv, 17'd0};
        c_next.oim     = {17'd0, mim} >= {s2_reg.dv, 17'd0};
        c_next.dv      = s2_reg.dv;
        c_next.srem    = s2_reg.sv;
        c_next.root    = '0;
        c_next.cx      = signed'({7'd0, s2_reg.ax, 24'd0});
        c_next.cy      = signed'({7'd0, s2_reg.ay, 24'd0});
        c_next.cz      = '0;
        c_next.origin  = s2_reg.ar_zero && s2_reg.ai_zero;
        c_next.ar_zero = s2_reg.ar_zero;
        c_next.ar_neg  = s2_reg.ar_neg;
        c_next.ai_zero = s2_reg.ai_zero;
        c_next.ai_neg  = s2_reg.ai_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            c_reg  <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            c_reg  <= c_next;
        end
    end

    assign cell_out = c_reg;

endmodule

[src/cau_cell.sv]
// ----------------------------------------------------------------------------
// Complex ALU chain cell
// Divide bit per quotient; root bit if IDX < 32; CORDIC rotation if IDX < 24.
// ----------------------------------------------------------------------------
module cau_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  cau_pkg::cell_t  cell_in,
    output cau_pkg::cell_t  cell_out
);
    import cau_pkg::*;

    localparam int DB = DIV_STEPS - 1 - IDX;

    cell_t       c_reg, c_next;
    logic [63:0] srem_n;
    logic [31:0] root_n;
    logic signed [63:0] cx_n, cy_n, cz_n;

    // restoring divide, both quotients
    logic [96:0] dsh;
    logic        ge_re, ge_im;
    assign dsh   = 97'(cell_in.dv) << DB;
    assign ge_re = {17'd0, cell_in.rre} >= dsh;
    assign ge_im = {17'd0, cell_in.rim} >= dsh;

    // square root digit
    if (IDX < SQRT_STEPS)
    begin : g_sqrt
        localparam int K = SQRT_STEPS - 1 - IDX;
        logic [65:0] t;
        logic        ge;
        assign t      = (66'(cell_in.root) << (K + 1)) + (66'd1 << (2 * K));
        assign ge     = {2'd0, cell_in.srem} >= t;
        assign srem_n = ge ? cell_in.srem - t[63:0] : cell_in.srem;
        assign root_n = ge ? cell_in.root | (32'd1 << K) : cell_in.root;
    end
    else
    begin : g_nosqrt
        assign srem_n = cell_in.srem;
        assign root_n = cell_in.root;
    end

    // vectoring CORDIC rotation
    if (IDX < CORDIC_STEPS)
    begin : g_cordic
        localparam logic signed [63:0] ATAN = atan_step(IDX);
        logic signed [63:0] dx, dy;
        assign dx = cell_in.cy >>> IDX;
        assign dy = cell_in.cx >>> IDX;
        assign cx_n = cell_in.cy[63] ? cell_in.cx - dx : cell_in.cx + dx;
        assign cy_n = cell_in.cy[63] ? cell_in.cy + dy : cell_in.cy - dy;
        assign cz_n = cell_in.cy[63] ? cell_in.cz - ATAN : cell_in.cz + ATAN;
    end
    else
    begin : g_nocordic
        assign cx_n = cell_in.cx;
        assign cy_n = cell_in.cy;
        assign cz_n = cell_in.cz;
    end

    always_comb
    begin
        c_next      = cell_in;
        c_next.rre  = ge_re ? cell_in.rre - dsh[79:0] : cell_in.rre;
        c_next.rim  = ge_im ? cell_in.rim - dsh[79:0] : cell_in.rim;
        c_next.qre  = {cell_in.qre[31:0], ge_re};
        c_next.qim  = {cell_in.qim[31:0], ge_im};
        c_next.srem = srem_n;
        c_next.root = root_n;
        c_next.cx   = cx_n;
        c_next.cy   = cy_n;
        c_next.cz   = cz_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_reg <= '0;
        else if (en)
            c_reg <= c_next;
    end

    assign cell_out = c_reg;

endmodule

[src/cau_back.sv]
// ----------------------------------------------------------------------------
// Complex ALU back end
// Quotient and modulus saturation, quadrant fix of the argument, output register.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  cau_pkg::cell_t      cell_in,
    output logic                out_valid,
    output logic signed [31:0]  out_re,
    output logic signed [31:0]  out_im,
    output logic                equal,
    output logic [1:0]          status
);
    import cau_pkg::*;

    localparam logic signed [63:0] PI_S  = signed'(PI_Q60);
    localparam logic signed [63:0] PIH_S = signed'(PI_Q60 >> 1);
    localparam logic signed [63:0] RND   = 64'sd1 <<< (ANG_FRAC - FB - 1);

    logic               valid_reg, valid_next;
    logic signed [31:0] re_reg, re_next;
    logic signed [31:0] im_reg, im_next;
    logic               eq_reg, eq_next;
    logic [1:0]         st_reg, st_next;

    // quotient from sign and magnitude, clipped at the 32 bit range
    function automatic logic [32:0] qsat(input logic neg, input logic ovf,
                                         input logic [32:0] q);
        logic [32:0] r;
        logic [32:0] nq;
        nq = 33'(-q);
        if (!neg)
            r = (ovf || q[32] || q[31]) ? {1'b1, 32'h7FFFFFFF} : {1'b0, q[31:0]};
        else
            r = (ovf || q[32] || (q[31] && (q[30:0] != 31'd0)))
                ? {1'b1, 32'h80000000} : {1'b0, nq[31:0]};
        return r;
    endfunction

    always_comb
    begin
        logic [32:0] sr;
        logic [32:0] si;
        logic signed [63:0] ang;
        logic signed [63:0] angr;
        sr = {cell_in.clip, cell_in.re};
        si = 33'(cell_in.im);
        ang = '0;
        if (cell_in.ar_zero)
            ang = cell_in.ai_neg ? -PIH_S : PIH_S;
        else if (!cell_in.ar_neg)
            ang = cell_in.ai_neg ? -cell_in.cz : cell_in.cz;
        else if (cell_in.ai_zero)
            ang = -PI_S;
        else if (!cell_in.ai_neg)
            ang = PI_S - cell_in.cz;
        else
            ang = cell_in.cz - PI_S;
        angr = (ang + RND) >>> (ANG_FRAC - FB);
        st_next = ST_OK;
        unique case (cell_in.kind)
            K_DIV:
            begin
                if (cell_in.dzero)
                begin
                    sr = '0;
                    si = '0;
                    st_next = ST_DIVZ;
                end
                else
                begin
                    sr = qsat(cell_in.nre, cell_in.ore, cell_in.qre);
                    si = qsat(cell_in.nim, cell_in.oim, cell_in.qim);
                    st_next = (sr[32] || si[32]) ? ST_SAT : ST_OK;
                end
            end
            K_POLAR:
            begin
                if (cell_in.origin)
                begin
                    sr = '0;
                    si = '0;
                    st_next = ST_ARG;
                end
                else
                begin
                    sr = cell_in.root[31] ? {1'b1, 32'h7FFFFFFF}
                                          : {1'b0, cell_in.root};
                    si = {1'b0, angr[31:0]};
                    st_next = sr[32] ? ST_SAT : ST_OK;
                end
            end
            default: st_next = cell_in.clip ? ST_SAT : ST_OK;
        endcase
        valid_next = cell_in.valid;
        re_next    = sr[31:0];
        im_next    = si[31:0];
        eq_next    = cell_in.eq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            re_reg    <= '0;
            im_reg    <= '0;
            eq_reg    <= 1'b0;
            st_reg    <= ST_OK;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
            re_reg    <= re_next;
            im_reg    <= im_next;
            eq_reg    <= eq_next;
            st_reg    <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = re_reg;
    assign out_im    = im_reg;
    assign equal     = eq_reg;
    assign status    = st_reg;

endmodule

[src/complex_arithmetic_unit_top.sv]
// Throughput: one item per cycle unless the output stalls; a row of 33 cells
// (one divide bit each, one square root bit in the first 32 and one CORDIC
// rotation in the first 24) sets the depth.
// A stalled output holds the whole pipeline until the result is taken.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the
// compare tolerance to zero.
// ----------------------------------------------------------------------------
// Complex arithmetic unit top level
// Fixed point Q16.16 complex ALU with a stream interface and tolerance register.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top (
    input  logic         clk,
    input  logic         rst_n,
    // stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re[31:0], a_im[63:32], b_re[95:64], b_im[127:96]
    input  logic [3:0]   s_tuser,   // kind[3:0]
    // stream out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // out_re[31:0], out_im[63:32], equal[64], zero pad
    output logic [1:0]   m_tuser,   // status[1:0]
    // tolerance write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data   // compare_tolerance
);
    import cau_pkg::*;

    logic               en;
    logic [15:0]        tol_reg;
    cell_t              chain [NUM_CELLS + 1];
    logic signed [31:0] out_re, out_im;
    logic               equal;
    logic [1:0]         status;

    // pipeline advances unless a result waits unaccepted
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .kind     (s_tuser),
        .a_re     (s_tdata[31:0]),
        .a_im     (s_tdata[63:32]),
        .b_re     (s_tdata[95:64]),
        .b_im     (s_tdata[127:96]),
        .tol      (tol_reg),
        .cell_out (chain[0])
    );

    // row of cells
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        cau_cell #(.IDX(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (chain[g]),
            .cell_out (chain[g + 1])
        );
    end

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cell_in   (chain[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_re    (out_re),
        .out_im    (out_im),
        .equal     (equal),
        .status    (status)
    );

    assign m_tdata = {7'd0, equal, out_im, out_re};
    assign m_tuser = status;

`ifndef NO_ASSERTIONS
    // a zero divisor or origin gives zero components
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_DIVZ || m_tuser == ST_ARG) |-> m_tdata[63:0] == 64'd0)
        else $error("error result with nonzero data");

    // a compare hit never carries an error status
    a_eq_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[64] |-> m_tuser == ST_OK)
        else $error("equal flag with nonzero status");

    // while stalled the output stage holds its valid
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> m_tvalid)
        else $error("output lost during stall");
`endif

endmodule

[tb/tb_complex_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Streams directed and random Q16.16 operand pairs of every operation kind
// through the block under changing input and output idling. Each result is
// checked against an in-bench bit-exact predictor. The compare tolerance is
// rewritten between phases.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit_top;

    import cau_pkg::*;

    // one operand set as it enters the block
    typedef struct {
        logic [3:0]         kind;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } op_item_t;

    // one result as it leaves the block
    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               eq;
        logic [1:0]         status;
    } cplx_res_t;

    localparam int LATENCY   = 36;
    localparam int WDOG_LIMIT = 5000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // a_re[31:0], a_im[63:32], b_re[95:64], b_im[127:96]
    logic [3:0]   s_tuser;   // kind[3:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // out_re[31:0], out_im[63:32], equal[64], zero pad
    logic [1:0]   m_tuser;   // status[1:0]
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;  // compare_tolerance

    op_item_t  op_queue[$];
    cplx_res_t expected_results[$];
    longint    atan_tab[CORDIC_STEPS];
    logic [15:0] tolerance;
    int        snd_idle_pct;
    int        rcv_idle_pct;
    int        error_count;
    int        result_count;
    int        hold_cnt;
    bit        hold_done;
    int        kind_count[16];
    int        wdog;

    complex_arithmetic_unit_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // clip to 32 bits signed
    function automatic logic signed [31:0] clip32(input logic signed [65:0] v, inout bit clip);
        if (v > 66'sd2147483647)
        begin
            clip = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -66'sd2147483648)
        begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // n * 2^16 / d truncated toward zero, clipped by sign and magnitude
    function automatic logic signed [31:0] div_q16(input logic signed [65:0] n,
                                                   input logic [65:0] d, inout bit clip);
        logic        neg;
        logic [65:0] mag;
        logic [99:0] q;
        neg = n < 0;
        mag = neg ? -n : n;
        q   = ({34'd0, mag} << 16) / {34'd0, d};
        if (neg)
        begin
            if (q > 100'h80000000)
            begin
                clip = 1'b1;
                return 32'sh80000000;
            end
            return -q[31:0];
        end
        if (q > 100'h7FFFFFFF)
        begin
            clip = 1'b1;
            return 32'sh7FFFFFFF;
        end
        return q[31:0];
    endfunction

    // floor of the square root, one result bit per pass
    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] b;
        root = 64'd0;
        b    = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= root + b)
            begin
                s    = s - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // first-quadrant angle by vectoring rotations, 60 fraction bits
    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        x = x <<< CORDIC_GUARD;
        y = y <<< CORDIC_GUARD;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[i];
            end
        end
        return z;
    endfunction

    // expected result of one operation
    function automatic cplx_res_t predict_result(input op_item_t it);
        cplx_res_t   r;
        logic signed [65:0] ar;
        logic signed [65:0] ai;
        logic signed [65:0] br;
        logic signed [65:0] bi;
        logic [65:0] d;
        logic [65:0] d_im;
        logic [63:0] root;
        longint      pi;
        longint      z;
        longint      ang;
        bit          clip;
        clip = 1'b0;
        r.re = '0;
        r.im = '0;
        r.eq = 1'b0;
        r.status = ST_OK;
        ar = it.a_re;
        ai = it.a_im;
        br = it.b_re;
        bi = it.b_im;
        pi = longint'(PI_Q60);
        case (it.kind)
            K_ADD:
            begin
                r.re = clip32(ar + br, clip);
                r.im = clip32(ai + bi, clip);
            end
            K_SUB:
            begin
                r.re = clip32(ar - br, clip);
                r.im = clip32(ai - bi, clip);
            end
            K_MUL:
            begin
                r.re = clip32((ar * br - ai * bi) >>> FB, clip);
                r.im = clip32((ar * bi + ai * br) >>> FB, clip);
            end
            K_DIV:
            begin
                d = br * br + bi * bi;
                if (d == 0)
                    r.status = ST_DIVZ;
                else
                begin
                    r.re = div_q16(ar * br + ai * bi, d, clip);
                    r.im = div_q16(ai * br - ar * bi, d, clip);
                end
            end
            K_NEG:
            begin
                r.re = clip32(-ar, clip);
                r.im = clip32(-ai, clip);
            end
            K_CONJ:
            begin
                r.re = it.a_re;
                r.im = clip32(-ai, clip);
            end
            K_SCALE:
            begin
                r.re = clip32((ar * br) >>> FB, clip);
                r.im = clip32((ai * br) >>> FB, clip);
            end
            K_POLAR:
            begin
                if (ar == 0 && ai == 0)
                    r.status = ST_ARG;
                else
                begin
                    root = floor_sqrt(64'(ar * ar + ai * ai));
                    r.re = clip32({2'b00, root}, clip);
                    if (ar == 0)
                        ang = (ai > 0) ? (pi >>> 1) : -(pi >>> 1);
                    else
                    begin
                        z = vector_angle(longint'(ar < 0 ? -ar : ar),
                                         longint'(ai < 0 ? -ai : ai));
                        if (ar > 0)
                            ang = (ai < 0) ? -z : z;
                        else if (ai == 0)
                            ang = -pi;
                        else if (ai > 0)
                            ang = pi - z;
                        else
                            ang = z - pi;
                    end
                    r.im = clip32((ang + (64'sd1 <<< (ANG_FRAC - FB - 1))) >>> (ANG_FRAC - FB),
                                  clip);
                end
            end
            K_CMP:
            begin
                d    = (ar >= br) ? ar - br : br - ar;
                d_im = (ai >= bi) ? ai - bi : bi - ai;
                r.eq = (d <= tolerance) && (d_im <= tolerance);
            end
            default: ;
        endcase
        if (clip && r.status == ST_OK)
            r.status = ST_SAT;
        return r;
    endfunction

    // operand value: mostly random, with a share of small and edge values
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3:       return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
            4:       return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
            5:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sh00000001;
                    3: return -32'sh1;
                    default: return '0;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
        endcase
    endfunction

    function automatic op_item_t make_op(input logic [3:0] k, input logic signed [31:0] ar,
                                         input logic signed [31:0] ai,
                                         input logic signed [31:0] br,
                                         input logic signed [31:0] bi);
        op_item_t it;
        it.kind = k;
        it.a_re = ar;
        it.a_im = ai;
        it.b_re = br;
        it.b_im = bi;
        return it;
    endfunction

    // random operation; compares mostly sit near the tolerance
    function automatic op_item_t random_op();
        op_item_t it;
        it.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
        it.a_re = pick_operand();
        it.a_im = pick_operand();
        it.b_re = pick_operand();
        it.b_im = pick_operand();
        if (it.kind == K_CMP && $urandom_range(0, 3) != 0)
        begin
            it.b_re = it.a_re + ($signed($urandom_range(0, 140000)) - 70000);
            it.b_im = it.a_im + ($signed($urandom_range(0, 140000)) - 70000);
        end
        if (it.kind == K_POLAR && $urandom_range(0, 5) == 0)
            it.a_re = 0;
        return it;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            op_item_t it;
            if (s_tvalid && s_tready)
            begin
                it = make_op(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                             s_tdata[127:96]);
                expected_results.push_back(predict_result(it));
                kind_count[s_tuser]++;
            end
            if (s_tvalid && !s_tready)
                s_tvalid <= 1'b1;
            else if (op_queue.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct)
            begin
                it = op_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.kind;
                s_tdata  <= {it.b_im, it.b_re, it.a_im, it.a_re};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_cnt  = 0;
            hold_done = 1'b0;
        end
        else
        begin
            cplx_res_t want;
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result re=%h im=%h eq=%b st=%0d", $time,
                             m_tdata[31:0], m_tdata[63:32], m_tdata[64], m_tuser);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.re || m_tdata[63:32] !== want.im ||
                        m_tdata[64] !== want.eq || m_tuser !== want.status)
                    begin
                        error_count++;
                        $display("%0t: mismatch expected re=%h im=%h eq=%b st=%0d", $time,
                                 want.re, want.im, want.eq, want.status);
                        $display("%0t:          actual   re=%h im=%h eq=%b st=%0d", $time,
                                 m_tdata[31:0], m_tdata[63:32], m_tdata[64], m_tuser);
                    end
                end
                // one long back-pressure stretch late in the run
                if (result_count == 600 && !hold_done)
                begin
                    hold_cnt  = 200;
                    hold_done = 1'b1;
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // watchdog: cycles with work pending but no transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (op_queue.size() == 0 && expected_results.size() == 0))
            wdog <= 0;
        else if (wdog >= WDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
            $display("FAILURE");
            $finish;
        end
        else
            wdog <= wdog + 1;
    end

    // wait until everything sent has come back, then let the pipe drain;
    // sampled mid-cycle so the driver's updates have settled
    task automatic wait_drained();
        while (op_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        tolerance = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] tol, input int snd, input int rcv, input int n);
        wait_drained();
        write_tolerance(tol);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        repeat (n) op_queue.push_back(random_op());
    endtask

    // stimulus
    initial
    begin
        longint acc;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            acc = 0;
            if (i == 0)
                acc = longint'(PI_Q60 >> 2);
            else
                for (int k = 1; k * i <= ANG_FRAC; k += 2)
                    acc = (((k - 1) / 2) % 2 == 0) ? acc + longint'((64'd1 << (ANG_FRAC - k * i)) / k)
                                                   : acc - longint'((64'd1 << (ANG_FRAC - k * i)) / k);
            atan_tab[i] = acc;
        end
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        tolerance    = '0;
        snd_idle_pct = 35;
        rcv_idle_pct = 72;
        error_count  = 0;
        result_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: edges, saturation, zero divisor, polar axes and origin
        write_tolerance(16'd0);
        op_queue.push_back(make_op(K_ADD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                                   32'sh80000000));
        op_queue.push_back(make_op(K_ADD, 32'sh00010000, -32'sh20000, 32'sh8000, 32'sh1));
        op_queue.push_back(make_op(K_SUB, 32'sh80000000, 32'sh7FFFFFFF, 32'sh1, -32'sh1));
        op_queue.push_back(make_op(K_MUL, 32'sh00018000, -32'sh28000, 32'sh30000, 32'sh4000));
        op_queue.push_back(make_op(K_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                                   32'sh7FFFFFFF));
        op_queue.push_back(make_op(K_MUL, -32'sh1, 32'sh0, 32'sh1, 32'sh0));
        op_queue.push_back(make_op(K_DIV, 32'sh10000, 32'sh20000, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_DIV, 32'sh30000, -32'sh10000, 32'sh10000, 32'sh20000));
        op_queue.push_back(make_op(K_DIV, 32'sh7FFFFFFF, 32'sh80000000, 32'sh1, 32'sh0));
        op_queue.push_back(make_op(K_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                                   32'sh80000000));
        op_queue.push_back(make_op(K_NEG, 32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_CONJ, 32'sh80000000, 32'sh80000000, 32'sh5, 32'sh5));
        op_queue.push_back(make_op(K_SCALE, 32'sh7FFFFFFF, -32'sh10000, 32'sh20000, 32'sh1234));
        op_queue.push_back(make_op(K_POLAR, 32'sh0, 32'sh0, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_POLAR, 32'sh0, 32'sh10000, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_POLAR, 32'sh0, -32'sh10000, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_POLAR, -32'sh30000, 32'sh0, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_POLAR, 32'sh30000, 32'sh40000, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_POLAR, -32'sh30000, 32'sh40000, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_POLAR, -32'sh30000, -32'sh40000, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_POLAR, 32'sh80000000, 32'sh80000000, 32'sh0, 32'sh0));
        op_queue.push_back(make_op(K_CMP, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000));
        op_queue.push_back(make_op(K_CMP, 32'sh7FFFFFFF, 32'sh0, 32'sh80000000, 32'sh0));
        op_queue.push_back(make_op(4'd9, 32'sh1, 32'sh1, 32'sh1, 32'sh1));
        op_queue.push_back(make_op(4'd15, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh1, 32'sh1));
        repeat (200) op_queue.push_back(random_op());

        // random phases over several tolerance settings and idling mixes
        run_phase(16'hFFFF, 72, 35, 230);
        run_phase(16'($urandom), 0, 0, 120);
        run_phase(16'd1, 0, 0, 130);
        wait_drained();

        $display("Checked %0d results over kinds 0-8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 result_count, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
                 kind_count[4], kind_count[5], kind_count[6], kind_count[7], kind_count[8]);
        $display("Four tolerance settings, three idling mixes and one long output stall.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
